[rtl/tpq_pkg.sv]
// Shared types, codes and the weight-pair merge for the tree path top-two query core.
// Used by every module under rtl/; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tpq_pkg;

    localparam int NODE_W    = 10;
    localparam int DEPTH_W   = 10;
    localparam int LEVEL_W   = 4;
    localparam int WEIGHT_W  = 32;
    localparam int FUNC_W    = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Request function codes; the fourth code is dropped.
    typedef enum logic [FUNC_W-1:0] {
        FN_DEPTH = 2'd0,
        FN_LIFT  = 2'd1,
        FN_QUERY = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        CMD_DEPTH,
        CMD_LIFT,
        CMD_QUERY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [NODE_W-1:0]     node;
        logic                  node_ok;
        logic [NODE_W-1:0]     other;
        logic                  other_ok;
        logic [LEVEL_W-1:0]    level;
        logic [DEPTH_W-1:0]    depth;
        logic [NODE_W-1:0]     anc;
        logic                  anc_none;
        logic [WEIGHT_W-1:0]   hf;
        logic [WEIGHT_W-1:0]   hs;
    } cmd_t;

    // One lift-table entry: the ancestor and the weight pair of the jump.
    typedef struct packed {
        logic                  none;
        logic [NODE_W-1:0]     anc;
        logic [WEIGHT_W-1:0]   hf;
        logic [WEIGHT_W-1:0]   hs;
    } bank_ent_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] top;
        logic [WEIGHT_W-1:0] sec;
    } wpair_t;

    localparam wpair_t WPAIR_INIT = '{top: 32'hFFFF_FFFE, sec: 32'hFFFF_FFFD};

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QLOAD,
        ST_QSWAP,
        ST_LCHECK,
        ST_LJUMP,
        ST_LWAIT,
        ST_LDEPTH,
        ST_PSTART,
        ST_PCHECK,
        ST_PLAST,
        ST_PINNER,
        ST_POUTER,
        ST_DONE
    } state_t;

    // Folds one weight into a (largest, strictly second largest) pair.
    function automatic wpair_t fold1(wpair_t s, logic [WEIGHT_W-1:0] c);
        wpair_t r;
        r = s;
        if ($signed(c) > $signed(s.top))
        begin
            r.top = c;
            r.sec = s.top;
        end
        else if ($signed(c) > $signed(s.sec) && $signed(c) < $signed(s.top))
        begin
            r.sec = c;
        end
        return r;
    endfunction

    function automatic wpair_t fold2(wpair_t s, logic [WEIGHT_W-1:0] a,
                                     logic [WEIGHT_W-1:0] b);
        return fold1(fold1(s, a), b);
    endfunction

endpackage

`default_nettype wire

[rtl/tpq_front.sv]
// Front end: takes requests, checks their ranges and turns the useful ones into commands.
// Depends on tpq_pkg; feeds tpq_queue.
`timescale 1ns / 1ps
`default_nettype none

module tpq_front #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [tpq_pkg::FUNC_W-1:0]    func,
    input  logic [tpq_pkg::NODE_W-1:0]    node,
    input  logic [tpq_pkg::NODE_W-1:0]    other_node,
    input  logic [tpq_pkg::LEVEL_W-1:0]   level,
    input  logic [tpq_pkg::DEPTH_W-1:0]   depth_value,
    input  logic signed [10:0]            ancestor,
    input  logic signed [31:0]            heavy_first,
    input  logic signed [31:0]            heavy_second,
    input  logic                          q_full,
    input  logic                          clearing,
    output logic                          push,
    output tpq_pkg::cmd_t                 push_cmd
);
    import tpq_pkg::*;

    logic node_ok;
    logic other_ok;
    logic level_ok;
    logic anc_ok;
    logic keep;
    logic accept;

    assign node_ok  = {{(32-NODE_W){1'b0}}, node} < 32'(NODES);
    assign other_ok = {{(32-NODE_W){1'b0}}, other_node} < 32'(NODES);
    assign level_ok = {{(32-LEVEL_W){1'b0}}, level} < 32'(LEVELS);
    assign anc_ok   = !ancestor[10] && ({22'd0, ancestor[9:0]} < 32'(NODES));

    assign req_ready = !q_full && !clearing;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        keep              = 1'b0;
        push_cmd.kind     = CMD_QUERY;
        push_cmd.node     = node;
        push_cmd.node_ok  = node_ok;
        push_cmd.other    = other_node;
        push_cmd.other_ok = other_ok;
        push_cmd.level    = level;
        push_cmd.depth    = depth_value;
        push_cmd.anc      = ancestor[9:0];
        push_cmd.anc_none = !anc_ok;
        push_cmd.hf       = heavy_first;
        push_cmd.hs       = heavy_second;
        unique case (func)
            FN_DEPTH:
            begin
                keep          = node_ok;
                push_cmd.kind = CMD_DEPTH;
            end
            FN_LIFT:
            begin
                keep          = node_ok && level_ok;
                push_cmd.kind = CMD_LIFT;
            end
            FN_QUERY:
            begin
                keep          = 1'b1;
                push_cmd.kind = CMD_QUERY;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // Requests that change nothing are taken and dropped here.
    assign push = accept && keep;

endmodule

`default_nettype wire

[rtl/tpq_queue.sv]
// Short command queue between the front end and the table walker.
// Depends on tpq_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module tpq_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tpq_pkg::cmd_t   push_cmd,
    input  logic            pop,
    output tpq_pkg::cmd_t   head,
    output logic            full,
    output logic            empty
);
    import tpq_pkg::*;

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/tpq_back.sv]
// Back end: holds the depth and lift tables, runs table writes and walks them for queries.
// Depends on tpq_pkg; takes commands from tpq_queue and drives the result channel.
`timescale 1ns / 1ps
`default_nettype none

module tpq_back #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tpq_pkg::cmd_t                 q_head,
    input  logic                          q_empty,
    output logic                          pop,
    output logic                          clearing,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic signed [31:0]            top_weight,
    output logic signed [31:0]            second_weight
);
    import tpq_pkg::*;

    localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam logic [LW-1:0] TOP_LVL  = LW'(LEVELS - 1);
    localparam logic [NW-1:0] LAST_ROW = NW'(NODES - 1);

    state_t               state_reg, state_next;
    logic [NW-1:0]        clr_addr_reg, clr_addr_next;
    logic [LW-1:0]        lvl_reg, lvl_next;
    logic                 last_reg, last_next;
    logic                 out_valid_reg, out_valid_next;

    logic [NODE_W-1:0]    u_reg, u_next;
    logic [NODE_W-1:0]    v_reg, v_next;
    logic                 u_none_reg, u_none_next;
    logic                 v_none_reg, v_none_next;
    logic [DEPTH_W-1:0]   du_reg, du_next;
    logic [DEPTH_W-1:0]   dv_reg, dv_next;
    wpair_t               acc_reg, acc_next;
    wpair_t               inner_reg, inner_next;
    wpair_t               hv_reg, hv_next;
    wpair_t               out_reg, out_next;

    logic [DEPTH_W-1:0]   depth_mem [NODES];
    logic [DEPTH_W-1:0]   dep_u_rd_reg;
    logic [DEPTH_W-1:0]   dep_v_rd_reg;
    bank_ent_t            bank_u_rd_reg [LEVELS];
    bank_ent_t            bank_v_rd_reg [LEVELS];

    logic [NW-1:0]        u_addr;
    logic [NW-1:0]        v_addr;
    logic                 dep_we;
    logic [NW-1:0]        dep_waddr;
    logic [DEPTH_W-1:0]   dep_wdata;
    logic [NW-1:0]        bank_waddr;
    bank_ent_t            bank_wdata;
    logic                 lift_wr;

    logic [DEPTH_W-1:0]   du_rd;
    logic [DEPTH_W-1:0]   dv_rd;
    bank_ent_t            ent_u;
    bank_ent_t            ent_v;
    logic signed [31:0]   diff;
    logic signed [31:0]   jump_len;
    logic                 lift_take;
    logic                 same_node;

    assign u_addr = NW'(u_reg);
    assign v_addr = NW'(v_reg);

    assign clearing = state_reg == ST_CLEAR;
    assign pop      = (state_reg == ST_IDLE) && !q_empty;
    assign lift_wr  = pop && (q_head.kind == CMD_LIFT);

    // During the clearing pass one row of every table is written per cycle.
    assign dep_we     = clearing || (pop && (q_head.kind == CMD_DEPTH));
    assign dep_waddr  = clearing ? clr_addr_reg : NW'(q_head.node);
    assign dep_wdata  = clearing ? '0 : q_head.depth;
    assign bank_waddr = clearing ? clr_addr_reg : NW'(q_head.node);
    assign bank_wdata = clearing ? bank_ent_t'{none: 1'b1, anc: '0, hf: '0, hs: '0}
                                 : bank_ent_t'{none: q_head.anc_none, anc: q_head.anc,
                                               hf: q_head.hf, hs: q_head.hs};

    always_ff @(posedge clk)
    begin
        if (dep_we)
        begin
            depth_mem[dep_waddr] <= dep_wdata;
        end
        dep_u_rd_reg <= depth_mem[u_addr];
        dep_v_rd_reg <= depth_mem[v_addr];
    end

    for (genvar g = 0; g < LEVELS; g++)
    begin : g_bank
        bank_ent_t bank_mem [NODES];
        logic      bank_we;

        assign bank_we = clearing || (lift_wr && ({28'd0, q_head.level} == 32'(g)));

        always_ff @(posedge clk)
        begin
            if (bank_we)
            begin
                bank_mem[bank_waddr] <= bank_wdata;
            end
            bank_u_rd_reg[g] <= bank_mem[u_addr];
            bank_v_rd_reg[g] <= bank_mem[v_addr];
        end
    end

    // A missing node reads depth zero, no ancestor and a zero weight pair.
    always_comb
    begin
        du_rd = u_none_reg ? '0 : dep_u_rd_reg;
        dv_rd = v_none_reg ? '0 : dep_v_rd_reg;
        ent_u = bank_u_rd_reg[lvl_reg];
        ent_v = bank_v_rd_reg[lvl_reg];
        if (u_none_reg)
        begin
            ent_u = '{none: 1'b1, anc: '0, hf: '0, hs: '0};
        end
        if (v_none_reg)
        begin
            ent_v = '{none: 1'b1, anc: '0, hf: '0, hs: '0};
        end
    end

    assign diff      = $signed({22'd0, du_reg}) - $signed({22'd0, dv_reg});
    assign jump_len  = 32'sd1 <<< lvl_reg;
    assign lift_take = diff >= jump_len;
    assign same_node = (u_none_reg == v_none_reg) && (u_none_reg || (u_reg == v_reg));

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        lvl_next       = lvl_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        u_none_next    = u_none_reg;
        v_none_next    = v_none_reg;
        du_next        = du_reg;
        dv_next        = dv_reg;
        acc_next       = acc_reg;
        inner_next     = inner_reg;
        hv_next        = hv_reg;
        out_next       = out_reg;

        if (out_valid_reg && res_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ROW)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (pop && (q_head.kind == CMD_QUERY))
                begin
                    u_next      = q_head.node;
                    u_none_next = !q_head.node_ok;
                    v_next      = q_head.other;
                    v_none_next = !q_head.other_ok;
                    acc_next    = WPAIR_INIT;
                    last_next   = 1'b0;
                    state_next  = ST_QLOAD;
                end
            end
            ST_QLOAD:
            begin
                state_next = ST_QSWAP;
            end
            ST_QSWAP:
            begin
                // The deeper node climbs first.
                if (du_rd < dv_rd)
                begin
                    u_next      = v_reg;
                    v_next      = u_reg;
                    u_none_next = v_none_reg;
                    v_none_next = u_none_reg;
                    du_next     = dv_rd;
                    dv_next     = du_rd;
                end
                else
                begin
                    du_next = du_rd;
                    dv_next = dv_rd;
                end
                lvl_next   = TOP_LVL;
                state_next = ST_LCHECK;
            end
            ST_LCHECK:
            begin
                if (lift_take)
                begin
                    state_next = ST_LJUMP;
                end
                else if (lvl_reg == '0)
                begin
                    lvl_next   = TOP_LVL;
                    state_next = ST_PSTART;
                end
                else
                begin
                    lvl_next = lvl_reg - 1'b1;
                end
            end
            ST_LJUMP:
            begin
                acc_next    = fold2(acc_reg, ent_u.hf, ent_u.hs);
                u_next      = ent_u.anc;
                u_none_next = ent_u.none;
                state_next  = ST_LWAIT;
            end
            ST_LWAIT:
            begin
                state_next = ST_LDEPTH;
            end
            ST_LDEPTH:
            begin
                // The depth of the new node comes from the table, not from the jump length.
                du_next = du_rd;
                if (lvl_reg == '0)
                begin
                    lvl_next   = TOP_LVL;
                    state_next = ST_PSTART;
                end
                else
                begin
                    lvl_next   = lvl_reg - 1'b1;
                    state_next = ST_LCHECK;
                end
            end
            ST_PSTART:
            begin
                state_next = same_node ? ST_DONE : ST_PCHECK;
            end
            ST_PCHECK:
            begin
                if (!ent_u.none && !ent_v.none && (ent_u.anc != ent_v.anc))
                begin
                    inner_next  = fold2(WPAIR_INIT, ent_u.hf, ent_u.hs);
                    hv_next     = '{top: ent_v.hf, sec: ent_v.hs};
                    u_next      = ent_u.anc;
                    v_next      = ent_v.anc;
                    u_none_next = 1'b0;
                    v_none_next = 1'b0;
                    state_next  = ST_PINNER;
                end
                else if (lvl_reg == '0)
                begin
                    state_next = ST_PLAST;
                end
                else
                begin
                    lvl_next = lvl_reg - 1'b1;
                end
            end
            ST_PLAST:
            begin
                inner_next = fold2(WPAIR_INIT, ent_u.hf, ent_u.hs);
                hv_next    = '{top: ent_v.hf, sec: ent_v.hs};
                last_next  = 1'b1;
                state_next = ST_PINNER;
            end
            ST_PINNER:
            begin
                inner_next = fold2(inner_reg, hv_reg.top, hv_reg.sec);
                state_next = ST_POUTER;
            end
            ST_POUTER:
            begin
                acc_next = fold2(acc_reg, inner_reg.top, inner_reg.sec);
                if (last_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (lvl_reg == '0)
                begin
                    state_next = ST_PLAST;
                end
                else
                begin
                    lvl_next   = lvl_reg - 1'b1;
                    state_next = ST_PCHECK;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_next       = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            lvl_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            lvl_reg       <= lvl_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg      <= u_next;
        v_reg      <= v_next;
        u_none_reg <= u_none_next;
        v_none_reg <= v_none_next;
        du_reg     <= du_next;
        dv_reg     <= dv_next;
        acc_reg    <= acc_next;
        inner_reg  <= inner_next;
        hv_reg     <= hv_next;
        out_reg    <= out_next;
    end

    assign res_valid     = out_valid_reg;
    assign top_weight    = $signed(out_reg.top);
    assign second_weight = $signed(out_reg.sec);

endmodule

`default_nettype wire

[rtl/tree_path_top_two_max_query_core.sv]
// Top level of the tree path top-two weight query core: front end, command queue, walker.
// Depends on tpq_pkg, tpq_front, tpq_queue and tpq_back.
//
//   Channel   Handshake              Payload
//   request   req_valid / req_ready  func, node, other_node, level, depth_value,
//                                    ancestor, heavy_first, heavy_second
//   result    res_valid / res_ready  top_weight, second_weight
//
// A table write is made by the walker as it pops the command. While the deeper node
// climbs, a query looks at each level once; a climb taken passes through the jump, a wait
// for the table read and the depth read of the new node. Each shared jump takes one look
// and two merge steps, and the last edge a load and the same two merges, all through
// registered reads of the table memories.
// After reset a clearing pass over all NODES rows sets every depth to zero and every ancestor
// to none; requests wait until it ends. Four commands queue up while the walker is busy or
// a result waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

module tree_path_top_two_max_query_core #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [tpq_pkg::FUNC_W-1:0]    func,
    input  logic [tpq_pkg::NODE_W-1:0]    node,
    input  logic [tpq_pkg::NODE_W-1:0]    other_node,
    input  logic [tpq_pkg::LEVEL_W-1:0]   level,
    input  logic [tpq_pkg::DEPTH_W-1:0]   depth_value,
    input  logic signed [10:0]            ancestor,
    input  logic signed [31:0]            heavy_first,
    input  logic signed [31:0]            heavy_second,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic signed [31:0]            top_weight,
    output logic signed [31:0]            second_weight
);
    import tpq_pkg::*;

    cmd_t push_cmd;
    cmd_t q_head;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    logic clearing;

    tpq_front #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .func         (func),
        .node         (node),
        .other_node   (other_node),
        .level        (level),
        .depth_value  (depth_value),
        .ancestor     (ancestor),
        .heavy_first  (heavy_first),
        .heavy_second (heavy_second),
        .q_full       (q_full),
        .clearing     (clearing),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    tpq_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    tpq_back #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_head        (q_head),
        .q_empty       (q_empty),
        .pop           (pop),
        .clearing      (clearing),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .top_weight    (top_weight),
        .second_weight (second_weight)
    );

endmodule

`default_nettype wire

[bench/tree_path_top_two_max_query_checker.sv]
// Checker for the tree path top-two weight query core: mirrors the depth and lift tables,
// predicts each query result and compares it with the result channel.
// Depends on tpq_pkg for the request function codes.
`timescale 1ns / 1ps

module tree_path_top_two_max_query_checker #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_ready,
    input  logic [1:0]         func,
    input  logic [9:0]         node,
    input  logic [9:0]         other_node,
    input  logic [3:0]         level,
    input  logic [9:0]         depth_value,
    input  logic signed [10:0] ancestor,
    input  logic signed [31:0] heavy_first,
    input  logic signed [31:0] heavy_second,
    input  logic               res_valid,
    input  logic               res_ready,
    input  logic signed [31:0] top_weight,
    input  logic signed [31:0] second_weight,
    output int                 mismatches,
    output int                 results_owed
);

    localparam int NO_NODE   = -1;
    localparam int TOP_START = -2;
    localparam int SEC_START = -3;
    localparam int MAX_SHOWN = 10;

    typedef struct {
        int hi;
        int lo;
    } weight_pair_t;

    logic [9:0]         depth_mem    [NODES];
    logic signed [10:0] anc_mem      [NODES*LEVELS];
    int                 heavy_hi_mem [NODES*LEVELS];
    int                 heavy_lo_mem [NODES*LEVELS];

    weight_pair_t expected_pairs[$];

    initial
    begin
        mismatches   = 0;
        results_owed = 0;
        for (int k = 0; k < NODES; k++)
        begin
            depth_mem[k] = '0;
        end
        for (int k = 0; k < NODES*LEVELS; k++)
        begin
            anc_mem[k]      = NO_NODE;
            heavy_hi_mem[k] = 0;
            heavy_lo_mem[k] = 0;
        end
    end

    // A missing node reads depth zero, no ancestor and the weights (0, 0).
    function automatic int depth_at(int n);
        if (n < 0)
        begin
            return 0;
        end
        return int'(depth_mem[n]);
    endfunction

    function automatic int anc_at(int n, int i);
        if (n < 0)
        begin
            return NO_NODE;
        end
        return int'(anc_mem[n*LEVELS+i]);
    endfunction

    function automatic weight_pair_t heavy_at(int n, int i);
        weight_pair_t p;
        p.hi = 0;
        p.lo = 0;
        if (n >= 0)
        begin
            p.hi = heavy_hi_mem[n*LEVELS+i];
            p.lo = heavy_lo_mem[n*LEVELS+i];
        end
        return p;
    endfunction

    // Every combination restarts from the sentinels and takes the four weights in order.
    function automatic weight_pair_t top_two_of(weight_pair_t a, weight_pair_t b);
        int           vals [4];
        int           t;
        int           s;
        weight_pair_t r;
        vals[0] = a.hi;
        vals[1] = a.lo;
        vals[2] = b.hi;
        vals[3] = b.lo;
        t = TOP_START;
        s = SEC_START;
        for (int k = 0; k < 4; k++)
        begin
            if (vals[k] > t)
            begin
                s = t;
                t = vals[k];
            end
            else if (vals[k] > s && vals[k] < t)
            begin
                s = vals[k];
            end
        end
        r.hi = t;
        r.lo = s;
        return r;
    endfunction

    function automatic weight_pair_t predict_path_top_two(int a, int b);
        weight_pair_t acc;
        int           u;
        int           v;
        int           t;
        int           au;
        int           av;
        acc.hi = TOP_START;
        acc.lo = SEC_START;
        u = a;
        v = b;
        if (depth_at(u) < depth_at(v))
        begin
            t = u;
            u = v;
            v = t;
        end
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (depth_at(u) - depth_at(v) >= (1 << i))
            begin
                acc = top_two_of(acc, heavy_at(u, i));
                u   = anc_at(u, i);
            end
        end
        if (u != v)
        begin
            for (int i = LEVELS - 1; i >= 0; i--)
            begin
                au = anc_at(u, i);
                av = anc_at(v, i);
                if (au != NO_NODE && av != NO_NODE && au != av)
                begin
                    acc = top_two_of(acc, top_two_of(heavy_at(u, i), heavy_at(v, i)));
                    u   = au;
                    v   = av;
                end
            end
            acc = top_two_of(acc, top_two_of(heavy_at(u, 0), heavy_at(v, 0)));
        end
        return acc;
    endfunction

    task automatic take_request();
        int idx;
        int a;
        if (func == tpq_pkg::FN_DEPTH)
        begin
            depth_mem[node] = depth_value;
        end
        else if (func == tpq_pkg::FN_LIFT)
        begin
            if (int'(level) < LEVELS)
            begin
                idx = int'(node) * LEVELS + int'(level);
                a   = int'(ancestor);
                anc_mem[idx]      = (a >= 0 && a < NODES) ? a : NO_NODE;
                heavy_hi_mem[idx] = int'(heavy_first);
                heavy_lo_mem[idx] = int'(heavy_second);
            end
        end
        else if (func == tpq_pkg::FN_QUERY)
        begin
            expected_pairs.push_back(predict_path_top_two(int'(node), int'(other_node)));
            results_owed++;
        end
    endtask

    task automatic check_result();
        weight_pair_t want;
        if (expected_pairs.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
            begin
                $display("%0t: unexpected result top %0d second %0d", $realtime,
                         top_weight, second_weight);
            end
        end
        else
        begin
            want = expected_pairs.pop_front();
            results_owed--;
            if (int'(top_weight) != want.hi || int'(second_weight) != want.lo)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                begin
                    $display("%0t: result mismatch: expected top %0d second %0d, got %0d %0d",
                             $realtime, want.hi, want.lo, top_weight, second_weight);
                end
            end
        end
    endtask

    // The result is checked first, as a query taken in this cycle cannot have answered yet.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            check_result();
        end
        if (rst_n && req_valid && req_ready)
        begin
            take_request();
        end
    end

endmodule

[bench/tree_path_top_two_max_query_core_tb.sv]
// Testbench top for the tree path top-two weight query core: clock, reset, request stimulus
// and result back-pressure. Depends on tpq_pkg, the core and tree_path_top_two_max_query_checker.
`timescale 1ns / 1ps

module tree_path_top_two_max_query_core_tb;

    localparam int          NODES        = 1024;
    localparam int          LEVELS       = 10;
    localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
    localparam int          NO_NODE      = -1;
    localparam int          NEW_PER_SET  = 6;
    localparam int          MIX_ITEMS    = 75;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          STILL_LIMIT  = 4000;
    localparam int          DRAIN_CYCLES = 120;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               req_valid    = 1'b0;
    logic               req_ready;
    logic [1:0]         func         = '0;
    logic [9:0]         node         = '0;
    logic [9:0]         other_node   = '0;
    logic [3:0]         level        = '0;
    logic [9:0]         depth_value  = '0;
    logic signed [10:0] ancestor     = '0;
    logic signed [31:0] heavy_first  = '0;
    logic signed [31:0] heavy_second = '0;
    logic               res_valid;
    logic               res_ready    = 1'b0;
    logic signed [31:0] top_weight;
    logic signed [31:0] second_weight;

    int mismatches;
    int results_owed;

    int idle_pct      = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int still_cycles  = 0;

    // Nodes whose every level has been loaded; their ancestors point only here or to none.
    int pool[$];
    bit in_pool  [NODES];
    bit reserved [NODES];

    always #10 clk = ~clk;

    tree_path_top_two_max_query_core #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .func          (func),
        .node          (node),
        .other_node    (other_node),
        .level         (level),
        .depth_value   (depth_value),
        .ancestor      (ancestor),
        .heavy_first   (heavy_first),
        .heavy_second  (heavy_second),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .top_weight    (top_weight),
        .second_weight (second_weight)
    );

    tree_path_top_two_max_query_checker #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .func          (func),
        .node          (node),
        .other_node    (other_node),
        .level         (level),
        .depth_value   (depth_value),
        .ancestor      (ancestor),
        .heavy_first   (heavy_first),
        .heavy_second  (heavy_second),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .top_weight    (top_weight),
        .second_weight (second_weight),
        .mismatches    (mismatches),
        .results_owed  (results_owed)
    );

    // Result side: random stalls, or a long hold-off when the stimulus asks for one.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            res_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            res_ready   <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end
        else
        begin
            res_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (res_valid && res_ready))
        begin
            still_cycles <= 0;
        end
        else if (still_cycles >= STILL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            still_cycles <= still_cycles + 1;
        end
    end

    task automatic send_request(input logic [1:0] f, input int n, input int o, input int l,
                                input int d, input int a, input int hf, input int hs);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid    <= 1'b1;
        func         <= f;
        node         <= n[9:0];
        other_node   <= o[9:0];
        level        <= l[3:0];
        depth_value  <= d[9:0];
        ancestor     <= a[10:0];
        heavy_first  <= hf;
        heavy_second <= hs;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_depth(input int n, input int d);
        send_request(tpq_pkg::FN_DEPTH, n, $urandom, $urandom, d, $urandom, $urandom, $urandom);
    endtask

    task automatic send_lift(input int n, input int l, input int a, input int hf, input int hs);
        send_request(tpq_pkg::FN_LIFT, n, $urandom, l, $urandom, a, hf, hs);
    endtask

    task automatic send_query(input int a, input int b);
        send_request(tpq_pkg::FN_QUERY, a, b, $urandom, $urandom, $urandom, $urandom,
                     $urandom);
    endtask

    function automatic int random_weight();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return int'($urandom_range(0, 8)) - 4;
            default: return int'($urandom);
        endcase
    endfunction

    function automatic int second_weight_for(int hf);
        case ($urandom_range(0, 6))
            0:       return -1;
            1:       return hf;
            default: return random_weight();
        endcase
    endfunction

    function automatic int pick_ancestor();
        case ($urandom_range(0, 9))
            0, 1:    return NO_NODE;
            2:       return -int'($urandom_range(2, 1024));
            default: return pool[$urandom_range(0, pool.size() - 1)];
        endcase
    endfunction

    function automatic int pick_depth();
        case ($urandom_range(0, 2))
            0:       return $urandom_range(0, 7);
            1:       return $urandom_range(0, 63);
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    function automatic int pick_outsider();
        int n;
        n = $urandom_range(0, NODES - 1);
        while (in_pool[n])
        begin
            n = $urandom_range(0, NODES - 1);
        end
        return n;
    endfunction

    task automatic grow_pool();
        int fresh[$];
        int n;
        int hf;
        for (int k = 0; k < NEW_PER_SET; k++)
        begin
            n = pick_outsider();
            while (reserved[n])
            begin
                n = pick_outsider();
            end
            in_pool[n] = 1'b1;
            pool.push_back(n);
            fresh.push_back(n);
        end
        // No query is issued until every level of every new node is loaded.
        foreach (fresh[k])
        begin
            send_depth(fresh[k], pick_depth());
            for (int l = 0; l < LEVELS; l++)
            begin
                hf = random_weight();
                send_lift(fresh[k], l, pick_ancestor(), hf, second_weight_for(hf));
            end
        end
    endtask

    task automatic random_mix(input int count);
        int done;
        int r;
        int a;
        int b;
        int l;
        int hf;
        done = 0;
        while (done < count)
        begin
            r = $urandom_range(0, 99);
            a = pool[$urandom_range(0, pool.size() - 1)];
            if (r < 55)
            begin
                b = ($urandom_range(0, 9) == 0) ? a : pool[$urandom_range(0, pool.size() - 1)];
                send_query(a, b);
                done++;
            end
            else if (r < 65)
            begin
                send_depth(a, pick_depth());
                done++;
            end
            else if (r < 77)
            begin
                l  = $urandom_range(0, 15);
                hf = random_weight();
                send_lift(a, l, pick_ancestor(), hf, second_weight_for(hf));
                if (l < LEVELS)
                begin
                    done++;
                end
            end
            else if (r < 87)
            begin
                // Writes to nodes outside the pool are never reached by a query.
                if ($urandom_range(0, 1) == 0)
                begin
                    send_depth(pick_outsider(), $urandom_range(0, 1023));
                    done++;
                end
                else
                begin
                    l = $urandom_range(0, 15);
                    send_lift(pick_outsider(), l, $urandom, random_weight(), $urandom);
                    if (l < LEVELS)
                    begin
                        done++;
                    end
                end
            end
            else
            begin
                send_request(FUNC_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom);
            end
        end
    endtask

    initial
    begin
        reserved[0]    = 1'b1;
        reserved[512]  = 1'b1;
        reserved[1023] = 1'b1;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Weight extremes, equal weights, out-of-range ancestor and ignored requests.
        send_lift(0, 0, NO_NODE, 32'h7FFF_FFFF, 32'h8000_0000);
        send_lift(1023, 0, -1024, -1, -1);
        send_query(0, 1023);
        send_query(1023, 1023);
        send_request(FUNC_UNUSED, 1023, 1023, 15, 1023, -1, -1, -1);
        send_lift(0, 15, 5, random_weight(), random_weight());
        send_lift(0, 10, 1023, random_weight(), random_weight());
        send_lift(512, 9, 1023, -2, -3);
        send_depth(512, 512);
        send_query(512, 0);
        send_query(0, 512);
        send_lift(0, 0, 1023, -3, -2);
        send_query(0, 1023);
        send_lift(1023, 0, 0, 32'h8000_0000, 32'h8000_0000);
        send_query(512, 0);
        send_query(1023, 0);
        send_depth(0, 0);
        send_depth(1023, 1023);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 54;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 54;
                end
                default:
                begin
                    idle_pct  = 30;
                    stall_pct = 30;
                end
            endcase
            grow_pool();
            if (phase == 0)
            begin
                hold_requests = hold_requests + 1;
            end
            random_mix(MIX_ITEMS);
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (results_owed != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && results_owed == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[tree_path_top_two_max_query_core.f]
rtl/tpq_pkg.sv
rtl/tpq_front.sv
rtl/tpq_queue.sv
rtl/tpq_back.sv
rtl/tree_path_top_two_max_query_core.sv
bench/tree_path_top_two_max_query_checker.sv
bench/tree_path_top_two_max_query_core_tb.sv
